>>> rtl/core/gptp_sync_send_fsm_macros.svh
// assertion helpers for the sync sender
`ifndef GPTP_SYNC_SEND_FSM_MACROS_SVH
`define GPTP_SYNC_SEND_FSM_MACROS_SVH

// same-cycle implication, held off while reset is low
`define GSYNC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off while reset is low
`define GSYNC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/gsync_pkg.sv
`default_nettype none

package gsync_pkg;

    localparam int unsigned SEQ_W  = 16;
    localparam int unsigned TIME_W = 64;
    localparam int unsigned LOG_W  = 8;
    localparam int unsigned OP_W   = 2;

    // request opcodes; the fourth code is unused
    localparam logic [OP_W-1:0] OP_STATUS    = 2'd0;
    localparam logic [OP_W-1:0] OP_SYNC_REQ  = 2'd1;
    localparam logic [OP_W-1:0] OP_TIMESTAMP = 2'd2;

    // frame kinds on the output
    localparam logic FRAME_SYNC = 1'b0;
    localparam logic FRAME_FUP  = 1'b1;

    typedef enum logic [1:0] {
        ST_INIT = 2'd0,
        ST_SYNC = 2'd1,
        ST_FUP  = 2'd2
    } t_state;

    // one registered request
    typedef struct packed {
        logic [OP_W-1:0]          opcode;
        logic                     begin_req;
        logic                     instance_enable;
        logic                     port_oper;
        logic                     port_enabled;
        logic                     as_capable;
        logic                     asymmetry_mode;
        logic [TIME_W-1:0]        time_value;
        logic signed [TIME_W-1:0] correction_in;
        logic signed [LOG_W-1:0]  log_interval;
        logic [SEQ_W-1:0]         sequence_in;
        logic [SEQ_W-1:0]         init_sequence;
    } t_item;

    // one emitted frame
    typedef struct packed {
        logic                     frame_kind;
        logic [SEQ_W-1:0]         sequence_id;
        logic signed [TIME_W-1:0] correction_out;
        logic signed [LOG_W-1:0]  log_interval_out;
    } t_frame;

    // machine context; corr_base holds correction minus upstream time
    typedef struct packed {
        t_state                   state;
        logic                     sync_pending;
        logic                     ts_pending;
        logic [SEQ_W-1:0]         next_seq;
        logic [SEQ_W-1:0]         sent_seq;
        logic [TIME_W-1:0]        corr_base;
        logic signed [LOG_W-1:0]  log_int;
    } t_ctx;

endpackage

`default_nettype wire

>>> rtl/core/gsync_item_if.sv
`default_nettype none

interface gsync_item_if import gsync_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          opcode;
    logic                     begin_req;
    logic                     instance_enable;
    logic                     port_oper;
    logic                     port_enabled;
    logic                     as_capable;
    logic                     asymmetry_mode;
    logic [TIME_W-1:0]        time_value;
    logic signed [TIME_W-1:0] correction_in;
    logic signed [LOG_W-1:0]  log_interval;
    logic [SEQ_W-1:0]         sequence_in;
    logic [SEQ_W-1:0]         init_sequence;

    modport source (
        output valid, opcode, begin_req, instance_enable, port_oper, port_enabled,
               as_capable, asymmetry_mode, time_value, correction_in, log_interval,
               sequence_in, init_sequence,
        input  ready
    );

    modport sink (
        input  valid, opcode, begin_req, instance_enable, port_oper, port_enabled,
               as_capable, asymmetry_mode, time_value, correction_in, log_interval,
               sequence_in, init_sequence,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/core/gsync_frame_if.sv
`default_nettype none

interface gsync_frame_if import gsync_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic                     frame_kind;
    logic [SEQ_W-1:0]         sequence_id;
    logic signed [TIME_W-1:0] correction_out;
    logic signed [LOG_W-1:0]  log_interval_out;

    modport source (
        output valid, frame_kind, sequence_id, correction_out, log_interval_out,
        input  ready
    );

    modport sink (
        input  valid, frame_kind, sequence_id, correction_out, log_interval_out,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/core/gsync_eval.sv
`default_nettype none

module gsync_eval import gsync_pkg::*; (
    input  var t_item  i_item,
    input  var t_ctx   i_ctx,
    output var t_ctx   o_ctx,
    output logic       o_emit,
    output var t_frame o_frame
);

    logic             is_status;
    logic             is_req;
    logic             ts_ok;
    logic             do_eval;
    logic             port_ready;
    logic             sp_in;
    logic             tp_in;
    logic             force_init;
    logic             drop;
    t_state           st_mid;
    logic             sp_mid;
    logic             tp_mid;
    logic [SEQ_W-1:0] seq_mid;
    logic [SEQ_W-1:0] last_seq;
    logic             send_sync;
    logic             send_fup;

    // request decode and timestamp match against the last sync sent
    always_comb begin
        last_seq   = i_ctx.next_seq - {{(SEQ_W-1){1'b0}}, 1'b1};
        is_status  = (i_item.opcode == OP_STATUS);
        is_req     = (i_item.opcode == OP_SYNC_REQ);
        ts_ok      = (i_item.opcode == OP_TIMESTAMP) && (i_ctx.state == ST_SYNC)
                     && (i_item.sequence_in == last_seq);
        do_eval    = is_status || is_req || ts_ok;
        port_ready = i_item.port_oper && i_item.port_enabled && i_item.as_capable;
        sp_in      = is_req || i_ctx.sync_pending;
        tp_in      = ts_ok || i_ctx.ts_pending;
    end

    // forced return to initializing
    always_comb begin
        force_init = i_item.begin_req || !i_item.instance_enable || (sp_in && !port_ready);
        drop       = do_eval && force_init && (i_ctx.state != ST_INIT);
        st_mid     = drop ? ST_INIT : i_ctx.state;
        sp_mid     = drop ? 1'b0 : sp_in;
        tp_mid     = drop ? 1'b0 : tp_in;
        seq_mid    = drop ? i_item.init_sequence : i_ctx.next_seq;
    end

    // transition out of the current state
    always_comb begin
        send_sync = 1'b0;
        send_fup  = 1'b0;
        case (st_mid)
            ST_INIT, ST_FUP: begin
                send_sync = do_eval && sp_mid && port_ready && !i_item.asymmetry_mode;
            end
            ST_SYNC: begin
                send_fup = do_eval && tp_mid;
            end
            default: begin
                send_sync = 1'b0;
                send_fup  = 1'b0;
            end
        endcase
    end

    // next context
    always_comb begin
        o_ctx = i_ctx;
        if (do_eval) begin
            o_ctx.state        = st_mid;
            o_ctx.sync_pending = sp_mid;
            o_ctx.ts_pending   = tp_mid;
            o_ctx.next_seq     = seq_mid;
            if (is_req) begin
                o_ctx.corr_base = $unsigned(i_item.correction_in) - i_item.time_value;
                o_ctx.log_int   = i_item.log_interval;
            end
            case (st_mid)
                ST_INIT, ST_FUP: begin
                    if (send_sync) begin
                        o_ctx.state        = ST_SYNC;
                        o_ctx.sync_pending = 1'b0;
                        o_ctx.sent_seq     = seq_mid;
                        o_ctx.next_seq     = seq_mid + {{(SEQ_W-1){1'b0}}, 1'b1};
                    end
                end
                ST_SYNC: begin
                    if (send_fup) begin
                        o_ctx.state      = ST_FUP;
                        o_ctx.ts_pending = 1'b0;
                    end
                end
                default: begin
                    o_ctx.state = ST_INIT;
                end
            endcase
        end
    end

    // emitted frame
    always_comb begin
        o_emit                   = send_sync || send_fup;
        o_frame.frame_kind       = send_fup ? FRAME_FUP : FRAME_SYNC;
        o_frame.sequence_id      = send_fup ? i_ctx.sent_seq : seq_mid;
        o_frame.correction_out   = send_fup ? $signed(i_ctx.corr_base + i_item.time_value)
                                            : '0;
        o_frame.log_interval_out = is_req ? i_item.log_interval : i_ctx.log_int;
    end

endmodule

`default_nettype wire

>>> rtl/core/gptp_sync_send_fsm.sv
// Two-step gPTP sync sender for one port.
// Input channel i_item carries requests: status re-evaluation, a received
// sync request (upstream time, correction, log interval) or an egress
// timestamp report tagged with a sequence number. Output channel o_frame
// carries at most one frame per request: a sync (correction zero) or a
// follow-up whose correction is the held correction plus egress time minus
// upstream time, all modulo 2^64.
// A request is registered in the input register on acceptance and evaluated
// there; its frame is registered in the frame register that drives o_frame.
// One request is taken every cycle while o_frame is drained; the evaluation
// is combinational flag logic, a 16-bit increment and decrement and 64-bit math.
// Reset (synchronous, active low) empties both registers, puts the machine
// in initializing with both pending flags, the sequence and all held values
// at zero. When o_frame stalls, the frame register holds its frame and one
// more request may enter the input register; i_item.ready then drops until
// the frame is taken.
`default_nettype none

module gptp_sync_send_fsm import gsync_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    gsync_item_if.sink         i_item,
    gsync_frame_if.source      o_frame
);

    logic   r_in_valid;
    t_item  r_item;
    t_item  n_item;
    logic   r_out_valid;
    t_frame r_frame;
    t_ctx   r_ctx;
    t_ctx   n_ctx;
    logic   eval_emit;
    t_frame eval_frame;
    logic   advance;
    logic   accept;

    // handshake
    assign advance      = !r_out_valid || o_frame.ready;
    assign i_item.ready = !r_in_valid || advance;
    assign accept       = i_item.valid && i_item.ready;

    // gather the request payload
    always_comb begin
        n_item.opcode          = i_item.opcode;
        n_item.begin_req       = i_item.begin_req;
        n_item.instance_enable = i_item.instance_enable;
        n_item.port_oper       = i_item.port_oper;
        n_item.port_enabled    = i_item.port_enabled;
        n_item.as_capable      = i_item.as_capable;
        n_item.asymmetry_mode  = i_item.asymmetry_mode;
        n_item.time_value      = i_item.time_value;
        n_item.correction_in   = i_item.correction_in;
        n_item.log_interval    = i_item.log_interval;
        n_item.sequence_in     = i_item.sequence_in;
        n_item.init_sequence   = i_item.init_sequence;
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

    // state machine evaluation
    gsync_eval u_eval (
        .i_item  (r_item),
        .i_ctx   (r_ctx),
        .o_ctx   (n_ctx),
        .o_emit  (eval_emit),
        .o_frame (eval_frame)
    );

    // context update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctx <= '{state: ST_INIT, default: '0};
        end else if (r_in_valid && advance) begin
            r_ctx <= n_ctx;
        end
    end

    // frame register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid && eval_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid && eval_emit) begin
            r_frame <= eval_frame;
        end
    end

    assign o_frame.valid            = r_out_valid;
    assign o_frame.frame_kind       = r_frame.frame_kind;
    assign o_frame.sequence_id      = r_frame.sequence_id;
    assign o_frame.correction_out   = r_frame.correction_out;
    assign o_frame.log_interval_out = r_frame.log_interval_out;

endmodule

`default_nettype wire

>>> rtl/core/gsync_chk.sv
`default_nettype none

`include "gptp_sync_send_fsm_macros.svh"

module gsync_chk import gsync_pkg::*; (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_ready,
    input logic                     i_out_valid,
    input logic                     i_out_ready,
    input logic                     i_frame_kind,
    input logic [SEQ_W-1:0]         i_sequence_id,
    input logic signed [TIME_W-1:0] i_correction_out,
    input logic signed [LOG_W-1:0]  i_log_interval_out
);

    // a stalled frame holds
    `GSYNC_ASSERT_NEXT(a_frame_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_frame_kind) && $stable(i_sequence_id)
        && $stable(i_correction_out) && $stable(i_log_interval_out),
        "stalled frame changed")

    // request side only waits on a blocked frame
    `GSYNC_ASSERT_NOW(a_ready_cause, i_clk, i_rst_n, !i_in_ready,
        i_out_valid && !i_out_ready, "request blocked without a stalled frame")

    // a sync carries no correction
    `GSYNC_ASSERT_NOW(a_sync_corr, i_clk, i_rst_n, i_out_valid && (i_frame_kind == FRAME_SYNC),
        i_correction_out == '0, "sync frame with nonzero correction")

    // reset empties both sides
    `GSYNC_ASSERT_NEXT(a_reset_empty, i_clk, 1'b1, !i_rst_n,
        i_in_ready && !i_out_valid, "not empty after reset")

endmodule

bind gptp_sync_send_fsm gsync_chk u_gsync_chk (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_ready         (i_item.ready),
    .i_out_valid        (o_frame.valid),
    .i_out_ready        (o_frame.ready),
    .i_frame_kind       (o_frame.frame_kind),
    .i_sequence_id      (o_frame.sequence_id),
    .i_correction_out   (o_frame.correction_out),
    .i_log_interval_out (o_frame.log_interval_out)
);

`default_nettype wire

>>> tb/gptp_sync_send_fsm_tb.sv
module gptp_sync_send_fsm_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gsync_pkg::*;

    // fourth opcode, not named in the package
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int unsigned STUCK_LIMIT = 4000;
    localparam int unsigned RAND_PER_PHASE = 320;

    // one queued request; seq_match asks for the sequence of the sync in flight
    typedef struct {
        t_item req;
        bit    seq_match;
    } t_pend;

    logic i_clk;
    logic i_rst_n;

    gsync_item_if  item_bus ();
    gsync_frame_if frame_bus ();

    gptp_sync_send_fsm u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_bus),
        .o_frame (frame_bus)
    );

    t_pend  req_q[$];
    t_frame frames_due[$];
    t_item  cur_req;
    int     idle_pct;
    int     stall_pct;
    int     err_count;
    int unsigned stuck;

    // shadow of the sender state
    t_state             sh_state;
    logic               sh_sync_pend;
    logic               sh_ts_pend;
    logic [SEQ_W-1:0]   sh_next_seq;
    logic [SEQ_W-1:0]   sh_sent_seq;
    logic [TIME_W-1:0]  sh_up_time;
    logic [TIME_W-1:0]  sh_corr;
    logic [LOG_W-1:0]   sh_log;
    logic [TIME_W-1:0]  sh_egress;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // known input values before the first edge
    initial begin
        i_rst_n                  = 1'b0;
        item_bus.valid           = 1'b0;
        item_bus.opcode          = OP_STATUS;
        item_bus.begin_req       = 1'b0;
        item_bus.instance_enable = 1'b0;
        item_bus.port_oper       = 1'b0;
        item_bus.port_enabled    = 1'b0;
        item_bus.as_capable      = 1'b0;
        item_bus.asymmetry_mode  = 1'b0;
        item_bus.time_value      = '0;
        item_bus.correction_in   = '0;
        item_bus.log_interval    = '0;
        item_bus.sequence_in     = '0;
        item_bus.init_sequence   = '0;
        frame_bus.ready          = 1'b0;
    end

    // emit one expected frame with the held log interval
    task automatic queue_frame(input logic kind, input logic [SEQ_W-1:0] seq,
                               input logic [TIME_W-1:0] corr);
        t_frame f;
        f.frame_kind       = kind;
        f.sequence_id      = seq;
        f.correction_out   = corr;
        f.log_interval_out = sh_log;
        frames_due.push_back(f);
    endtask

    // status evaluation and one transition attempt
    task automatic evaluate_sender(input t_item it);
        logic port_ok;
        port_ok = it.port_oper & it.port_enabled & it.as_capable;
        if (it.begin_req || !it.instance_enable || (sh_sync_pend && !port_ok)) begin
            if (sh_state != ST_INIT) begin
                sh_state     = ST_INIT;
                sh_sync_pend = 1'b0;
                sh_ts_pend   = 1'b0;
                sh_next_seq  = it.init_sequence;
            end
        end
        case (sh_state)
            ST_INIT, ST_FUP: begin
                if (sh_sync_pend && port_ok && !it.asymmetry_mode) begin
                    sh_state     = ST_SYNC;
                    sh_sync_pend = 1'b0;
                    sh_sent_seq  = sh_next_seq;
                    queue_frame(FRAME_SYNC, sh_sent_seq, '0);
                    sh_next_seq  = sh_next_seq + 16'd1;
                end
            end
            ST_SYNC: begin
                if (sh_ts_pend) begin
                    sh_state   = ST_FUP;
                    sh_ts_pend = 1'b0;
                    queue_frame(FRAME_FUP, sh_sent_seq, sh_corr + (sh_egress - sh_up_time));
                end
            end
            default: sh_state = ST_INIT;
        endcase
    endtask

    // advance the shadow by one accepted request
    task automatic advance_sender(input t_item it);
        case (it.opcode)
            OP_STATUS: evaluate_sender(it);
            OP_SYNC_REQ: begin
                sh_up_time   = it.time_value;
                sh_corr      = it.correction_in;
                sh_log       = it.log_interval;
                sh_sync_pend = 1'b1;
                evaluate_sender(it);
            end
            OP_TIMESTAMP: begin
                if (sh_state == ST_SYNC && it.sequence_in == sh_next_seq - 16'd1) begin
                    sh_ts_pend = 1'b1;
                    sh_egress  = it.time_value;
                    evaluate_sender(it);
                end
            end
            default: ;
        endcase
    endtask

    function automatic logic [TIME_W-1:0] rand_time();
        logic [TIME_W-1:0] t;
        case ($urandom_range(0, 19))
            0: t = '0;
            1: t = '1;
            2: t = {1'b1, {(TIME_W-1){1'b0}}};
            3: t = {1'b0, {(TIME_W-1){1'b1}}};
            default: t = {$urandom, $urandom};
        endcase
        return t;
    endfunction

    // request from a ready, enabled, capable port with random content
    function automatic t_item healthy_req(input logic [OP_W-1:0] op);
        t_item r;
        r.opcode          = op;
        r.begin_req       = 1'b0;
        r.instance_enable = 1'b1;
        r.port_oper       = 1'b1;
        r.port_enabled    = 1'b1;
        r.as_capable      = 1'b1;
        r.asymmetry_mode  = 1'b0;
        r.time_value      = rand_time();
        r.correction_in   = rand_time();
        r.log_interval    = LOG_W'($urandom_range(0, 255));
        r.sequence_in     = SEQ_W'($urandom_range(0, 65535));
        r.init_sequence   = SEQ_W'($urandom_range(0, 65535));
        return r;
    endfunction

    // mostly well-formed traffic, with disturbances and noise
    function automatic t_pend rand_pend();
        t_pend p;
        int    pick;
        pick = $urandom_range(0, 99);
        if (pick < 30)      p.req = healthy_req(OP_STATUS);
        else if (pick < 65) p.req = healthy_req(OP_SYNC_REQ);
        else if (pick < 97) p.req = healthy_req(OP_TIMESTAMP);
        else                p.req = healthy_req(OP_UNUSED);
        p.seq_match = (p.req.opcode == OP_TIMESTAMP) && ($urandom_range(0, 9) != 0);
        if ($urandom_range(0, 99) < 8) begin
            // noise: every flag random
            p.req.begin_req       = 1'($urandom_range(0, 1));
            p.req.instance_enable = 1'($urandom_range(0, 1));
            p.req.port_oper       = 1'($urandom_range(0, 1));
            p.req.port_enabled    = 1'($urandom_range(0, 1));
            p.req.as_capable      = 1'($urandom_range(0, 1));
            p.req.asymmetry_mode  = 1'($urandom_range(0, 1));
        end else begin
            p.req.begin_req       = ($urandom_range(0, 99) < 3);
            p.req.instance_enable = ($urandom_range(0, 99) >= 3);
            p.req.port_oper       = ($urandom_range(0, 99) >= 3);
            p.req.port_enabled    = ($urandom_range(0, 99) >= 3);
            p.req.as_capable      = ($urandom_range(0, 99) >= 3);
            p.req.asymmetry_mode  = ($urandom_range(0, 99) < 5);
        end
        return p;
    endfunction

    task automatic add_req(input t_item r, input bit m);
        t_pend p;
        p.req       = r;
        p.seq_match = m;
        req_q.push_back(p);
    endtask

    // request driver
    always @(posedge i_clk) begin
        t_pend nx;
        logic  vld;
        vld = item_bus.valid;
        if (!i_rst_n) begin
            vld          = 1'b0;
            cur_req      = '0;
            sh_state     = ST_INIT;
            sh_sync_pend = 1'b0;
            sh_ts_pend   = 1'b0;
            sh_next_seq  = '0;
            sh_sent_seq  = '0;
            sh_up_time   = '0;
            sh_corr      = '0;
            sh_log       = '0;
            sh_egress    = '0;
        end else begin
            if (item_bus.valid && item_bus.ready) begin
                advance_sender(cur_req);
                vld = 1'b0;
            end
            if (!vld && req_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                nx = req_q.pop_front();
                if (nx.seq_match) nx.req.sequence_in = sh_next_seq - 16'd1;
                cur_req = nx.req;
                vld     = 1'b1;
            end
        end
        item_bus.valid           <= vld;
        item_bus.opcode          <= cur_req.opcode;
        item_bus.begin_req       <= cur_req.begin_req;
        item_bus.instance_enable <= cur_req.instance_enable;
        item_bus.port_oper       <= cur_req.port_oper;
        item_bus.port_enabled    <= cur_req.port_enabled;
        item_bus.as_capable      <= cur_req.as_capable;
        item_bus.asymmetry_mode  <= cur_req.asymmetry_mode;
        item_bus.time_value      <= cur_req.time_value;
        item_bus.correction_in   <= cur_req.correction_in;
        item_bus.log_interval    <= cur_req.log_interval;
        item_bus.sequence_in     <= cur_req.sequence_in;
        item_bus.init_sequence   <= cur_req.init_sequence;
    end

    function automatic bit field_ok(input string name, input logic [TIME_W-1:0] want,
                                    input logic [TIME_W-1:0] got);
        if (want !== got) begin
            $display("%0t: frame %s mismatch, expected %0h, got %0h", $time, name, want, got);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    // frame monitor
    always @(posedge i_clk) begin
        t_frame want;
        if (!i_rst_n) begin
            frame_bus.ready <= 1'b0;
        end else begin
            if (frame_bus.valid && frame_bus.ready) begin
                if (frames_due.size() == 0) begin
                    $display("%0t: unexpected frame, expected none, got kind %0h seq %0h",
                             $time, frame_bus.frame_kind, frame_bus.sequence_id);
                    err_count++;
                end else begin
                    want = frames_due.pop_front();
                    if (!field_ok("kind", {63'd0, want.frame_kind},
                                  {63'd0, frame_bus.frame_kind}))
                        err_count++;
                    if (!field_ok("sequence", {48'd0, want.sequence_id},
                                  {48'd0, frame_bus.sequence_id}))
                        err_count++;
                    if (!field_ok("correction", want.correction_out, frame_bus.correction_out))
                        err_count++;
                    if (!field_ok("log interval", {56'd0, want.log_interval_out},
                                  {56'd0, frame_bus.log_interval_out}))
                        err_count++;
                end
            end
            frame_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // watchdog on cycles without any handshake while work is outstanding
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stuck <= 0;
        end else if ((item_bus.valid && item_bus.ready) ||
                     (frame_bus.valid && frame_bus.ready) ||
                     (req_q.size() == 0 && !item_bus.valid && frames_due.size() == 0)) begin
            stuck <= 0;
        end else if (stuck >= STUCK_LIMIT) begin
            $display("gptp_sync_send_fsm verification failed");
            $finish;
        end else begin
            stuck <= stuck + 1;
        end
    end

    // stimulus sequencing
    initial begin
        t_item r;
        err_count = 0;
        idle_pct  = 0;
        stall_pct = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // unused opcode and a timestamp while initializing
        r = healthy_req(OP_UNUSED);                       add_req(r, 0);
        r = healthy_req(OP_TIMESTAMP); r.sequence_in = 16'hFFFF;
        add_req(r, 0);
        r = healthy_req(OP_STATUS);                       add_req(r, 0);
        // asymmetry mode holds the request back, then status sends it
        r = healthy_req(OP_SYNC_REQ); r.asymmetry_mode = 1'b1;
        r.time_value = '0; r.correction_in = {1'b0, {63{1'b1}}}; r.log_interval = 8'h80;
        add_req(r, 0);
        r = healthy_req(OP_STATUS);                       add_req(r, 0);
        // wrong sequence, then a newer request during send sync
        r = healthy_req(OP_TIMESTAMP); r.sequence_in = 16'd5;
        add_req(r, 0);
        r = healthy_req(OP_SYNC_REQ); r.time_value = '1;
        r.correction_in = {1'b1, {63{1'b0}}}; r.log_interval = 8'h7F;
        add_req(r, 0);
        // follow-up, then the chained sync on the next status
        r = healthy_req(OP_TIMESTAMP); r.time_value = '0;  add_req(r, 1);
        r = healthy_req(OP_STATUS);                       add_req(r, 0);
        r = healthy_req(OP_TIMESTAMP); r.time_value = '1;  add_req(r, 1);
        // link down with a pending request drops to initializing
        r = healthy_req(OP_SYNC_REQ); r.port_oper = 1'b0; r.init_sequence = 16'hFFFF;
        add_req(r, 0);
        // sequence wrap
        r = healthy_req(OP_SYNC_REQ); r.init_sequence = 16'h0000;
        add_req(r, 0);
        r = healthy_req(OP_TIMESTAMP);                    add_req(r, 1);
        // begin flag: from follow-up it clears, from initializing it sends
        r = healthy_req(OP_SYNC_REQ); r.begin_req = 1'b1; r.init_sequence = 16'h1234;
        add_req(r, 0);
        r = healthy_req(OP_SYNC_REQ); r.begin_req = 1'b1; r.init_sequence = 16'h5555;
        add_req(r, 0);
        // instance disabled, then a request while not capable
        r = healthy_req(OP_STATUS); r.instance_enable = 1'b0; r.init_sequence = 16'h8000;
        add_req(r, 0);
        r = healthy_req(OP_SYNC_REQ); r.as_capable = 1'b0;  add_req(r, 0);
        r = healthy_req(OP_STATUS); r.port_enabled = 1'b0;  add_req(r, 0);
        r = healthy_req(OP_STATUS);                         add_req(r, 0);
        // matching timestamp with begin set is lost
        r = healthy_req(OP_TIMESTAMP); r.begin_req = 1'b1;  add_req(r, 1);
        // wraparound of the correction sum
        r = healthy_req(OP_SYNC_REQ); r.time_value = '1; r.correction_in = '0;
        r.log_interval = 8'h00;
        add_req(r, 0);
        r = healthy_req(OP_TIMESTAMP); r.time_value = '0;  add_req(r, 1);
        r = healthy_req(OP_UNUSED);                        add_req(r, 0);

        // random traffic under four idling patterns
        for (int ph = 0; ph < 4; ph++) begin
            @(posedge i_clk);
            case (ph)
                0: begin idle_pct <= 0;  stall_pct <= 0;  end
                1: begin idle_pct <= 70; stall_pct <= 0;  end
                2: begin idle_pct <= 0;  stall_pct <= 70; end
                default: begin idle_pct <= 14; stall_pct <= 14; end
            endcase
            for (int n = 0; n < RAND_PER_PHASE; n++) req_q.push_back(rand_pend());
            while (req_q.size() != 0 || item_bus.valid || frames_due.size() != 0)
                @(posedge i_clk);
        end

        // drain
        repeat (20) @(posedge i_clk);
        if (err_count == 0 && frames_due.size() == 0) begin
            $display("gptp_sync_send_fsm verification clean");
        end else begin
            $display("gptp_sync_send_fsm verification failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/gsync_pkg.sv
rtl/core/gsync_item_if.sv
rtl/core/gsync_frame_if.sv
rtl/core/gsync_eval.sv
rtl/core/gptp_sync_send_fsm.sv
rtl/core/gsync_chk.sv
tb/gptp_sync_send_fsm_tb.sv
